// File: rtl/e2q_pkg.sv
`default_nettype none

package e2q_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    // stages past the end of the arctangent table are skipped
    localparam int NSTAGE = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    localparam int ANGLE_W = 16;
    localparam int ANG_W   = 34;   // 30 fraction bits, headroom for the unfolded half angle
    localparam int TRIG_W  = 18;   // sine/cosine, 16 fraction bits
    localparam int PAIR_W  = 2 * TRIG_W;
    localparam int TRIP_W  = 3 * TRIG_W;
    localparam int SUM_W   = TRIP_W + 1;
    localparam int Q_W     = 16;

    typedef logic signed [ANG_W-1:0]   ang_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [PAIR_W-1:0]  pair_t;
    typedef logic signed [TRIP_W-1:0]  trip_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [Q_W-1:0]     q_t;

    localparam ang_t ANG_PI      = 34'sh0C90FDAA2;
    localparam ang_t ANG_HALF_PI = 34'sh06487ED51;
    localparam ang_t CORDIC_GAIN = 34'sh026DD3B6A;
    localparam ang_t TRIG_ROUND  = 34'sh000002000;
    localparam sum_t OUT_ROUND   = 55'sh00000200000000;
    localparam sum_t Q_ONE       = 55'sh00000000004000;
    localparam sum_t Q_NEG_ONE   = -Q_ONE;

    localparam ang_t ATAN_TAB [TAB_LEN] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
    };

    // round half up from 48 to 14 fraction bits, clamp to plus or minus one
    function automatic q_t round_sat(input sum_t s);
        sum_t r;
        q_t   q;
        r = (s + OUT_ROUND) >>> 34;
        if (r > Q_ONE) begin
            q = Q_ONE[Q_W-1:0];
        end else if (r < Q_NEG_ONE) begin
            q = Q_NEG_ONE[Q_W-1:0];
        end else begin
            q = r[Q_W-1:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/euler_to_quaternion.sv
// channel  dir  tdata fields (lowest bit up)                         handshake
// s_       in   roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]  s_tvalid/s_tready
// m_       out  q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]         m_tvalid/m_tready
//
// one transaction per cycle sustained while the output is not stalled
// registers in order: fold, each CORDIC stage, round, pair products, triple products, output register
// reset clears only valid bits and the skid flag; no state is kept between transactions
// a one-entry skid behind the output register holds the stall, so s_tready is a register
`default_nettype none

module euler_to_quaternion (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata    // q_w, q_x, q_y, q_z
);

    localparam int NS = e2q_pkg::NSTAGE;
    // fold + cordic + round + pair + triple
    localparam int NP = NS + 4;

    logic                                      en;
    logic [NP-1:0]                             valid_reg;
    logic signed [e2q_pkg::ANGLE_W-1:0]        angle [3];
    e2q_pkg::trig_t                            sin_w [3];
    e2q_pkg::trig_t                            cos_w [3];

    e2q_pkg::pair_t crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    e2q_pkg::trig_t cy_reg, sy_reg;
    e2q_pkg::trip_t p_reg [8];

    e2q_pkg::q_t    q_w, q_x, q_y, q_z;
    logic [63:0]    fin_data;
    logic           incoming;
    logic           take;
    logic           skid_valid_reg;
    logic [63:0]    skid_data_reg;
    logic           m_tvalid_reg;
    logic [63:0]    m_tdata_reg;

    assign angle[0] = s_tdata[15:0];
    assign angle[1] = s_tdata[31:16];
    assign angle[2] = s_tdata[47:32];

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign take     = m_tvalid_reg && m_tready;
    assign incoming = en && valid_reg[NP-1];

    e2q_sincos u_sincos (
        .aclk     (aclk),
        .en       (en),
        .angle_in (angle),
        .sin_out  (sin_w),
        .cos_out  (cos_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NP-2:0], s_tvalid};
        end
    end

    // index 0 roll, 1 pitch, 2 yaw
    always_ff @(posedge aclk) begin
        if (en) begin
            crcp_reg <= cos_w[0] * cos_w[1];
            srsp_reg <= sin_w[0] * sin_w[1];
            srcp_reg <= sin_w[0] * cos_w[1];
            crsp_reg <= cos_w[0] * sin_w[1];
            cy_reg   <= cos_w[2];
            sy_reg   <= sin_w[2];
            p_reg[0] <= crcp_reg * cy_reg;
            p_reg[1] <= srsp_reg * sy_reg;
            p_reg[2] <= srcp_reg * cy_reg;
            p_reg[3] <= crsp_reg * sy_reg;
            p_reg[4] <= crsp_reg * cy_reg;
            p_reg[5] <= srcp_reg * sy_reg;
            p_reg[6] <= crcp_reg * sy_reg;
            p_reg[7] <= srsp_reg * cy_reg;
        end
    end

    always_comb begin
        q_w = e2q_pkg::round_sat(e2q_pkg::sum_t'(p_reg[0]) + e2q_pkg::sum_t'(p_reg[1]));
        q_x = e2q_pkg::round_sat(e2q_pkg::sum_t'(p_reg[2]) - e2q_pkg::sum_t'(p_reg[3]));
        q_y = e2q_pkg::round_sat(e2q_pkg::sum_t'(p_reg[4]) + e2q_pkg::sum_t'(p_reg[5]));
        q_z = e2q_pkg::round_sat(e2q_pkg::sum_t'(p_reg[6]) - e2q_pkg::sum_t'(p_reg[7]));
        fin_data = {q_z, q_y, q_x, q_w};
    end

    // output register with a skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || take) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= incoming;
            end
        end else if (incoming) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || take) begin
            if (skid_valid_reg) begin
                m_tdata_reg <= skid_data_reg;
            end else if (incoming) begin
                m_tdata_reg <= fin_data;
            end
        end else if (incoming) begin
            skid_data_reg <= fin_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid entry held while output register empty");

    a_skid_kept : assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost during stall");

    a_out_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(m_tdata_reg[15:0]) <= 16384 && $signed(m_tdata_reg[15:0]) >= -16384
            && $signed(m_tdata_reg[31:16]) <= 16384 && $signed(m_tdata_reg[31:16]) >= -16384
            && $signed(m_tdata_reg[47:32]) <= 16384 && $signed(m_tdata_reg[47:32]) >= -16384
            && $signed(m_tdata_reg[63:48]) <= 16384 && $signed(m_tdata_reg[63:48]) >= -16384))
        else $error("quaternion component outside unit range");

endmodule

`default_nettype wire

// File: rtl/e2q_sincos.sv
`default_nettype none

module e2q_sincos (
    input  wire                          aclk,
    input  wire                          en,
    input  wire logic signed [e2q_pkg::ANGLE_W-1:0] angle_in [3],
    output e2q_pkg::trig_t               sin_out [3],
    output e2q_pkg::trig_t               cos_out [3]
);

    localparam int NS = e2q_pkg::NSTAGE;

    for (genvar a = 0; a < 3; a++) begin : g_angle
        e2q_pkg::ang_t z_in;
        e2q_pkg::ang_t z_fold;
        logic          neg_fold;

        e2q_pkg::ang_t x_reg [NS+1];
        e2q_pkg::ang_t y_reg [NS+1];
        e2q_pkg::ang_t z_reg [NS+1];
        logic          neg_reg [NS+1];

        e2q_pkg::ang_t x_next [NS];
        e2q_pkg::ang_t y_next [NS];
        e2q_pkg::ang_t z_next [NS];

        e2q_pkg::ang_t x_fin;
        e2q_pkg::ang_t y_fin;
        e2q_pkg::ang_t c_full;
        e2q_pkg::ang_t s_full;
        e2q_pkg::trig_t sin_reg;
        e2q_pkg::trig_t cos_reg;

        // halve exactly: 12 fraction bits read as 13, moved to 30
        assign z_in = {angle_in[a][e2q_pkg::ANGLE_W-1], angle_in[a], 17'b0};

        always_comb begin
            z_fold   = z_in;
            neg_fold = 1'b0;
            if (z_in > e2q_pkg::ANG_HALF_PI) begin
                z_fold   = z_in - e2q_pkg::ANG_PI;
                neg_fold = 1'b1;
            end else if (z_in < -e2q_pkg::ANG_HALF_PI) begin
                z_fold   = z_in + e2q_pkg::ANG_PI;
                neg_fold = 1'b1;
            end
        end

        always_comb begin
            for (int i = 0; i < NS; i++) begin
                if (z_reg[i] >= 0) begin
                    x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                    y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                    z_next[i] = z_reg[i] - e2q_pkg::ATAN_TAB[i];
                end else begin
                    x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                    y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                    z_next[i] = z_reg[i] + e2q_pkg::ATAN_TAB[i];
                end
            end
        end

        always_comb begin
            x_fin  = neg_reg[NS] ? -x_reg[NS] : x_reg[NS];
            y_fin  = neg_reg[NS] ? -y_reg[NS] : y_reg[NS];
            c_full = (x_fin + e2q_pkg::TRIG_ROUND) >>> 14;
            s_full = (y_fin + e2q_pkg::TRIG_ROUND) >>> 14;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[0]   <= e2q_pkg::CORDIC_GAIN;
                y_reg[0]   <= '0;
                z_reg[0]   <= z_fold;
                neg_reg[0] <= neg_fold;
                for (int i = 0; i < NS; i++) begin
                    x_reg[i+1]   <= x_next[i];
                    y_reg[i+1]   <= y_next[i];
                    z_reg[i+1]   <= z_next[i];
                    neg_reg[i+1] <= neg_reg[i];
                end
                cos_reg <= c_full[e2q_pkg::TRIG_W-1:0];
                sin_reg <= s_full[e2q_pkg::TRIG_W-1:0];
            end
        end

        assign sin_out[a] = sin_reg;
        assign cos_out[a] = cos_reg;
    end

endmodule

`default_nettype wire

// File: test/e2q_checker.sv
module e2q_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [47:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [63:0] m_tdata,   // q_w, q_x, q_y, q_z
    output int          mismatch_count,
    output int          quats_due
);

    localparam int     STAGES     = (e2q_pkg::CORDIC_STAGES < 24) ? e2q_pkg::CORDIC_STAGES : 24;
    localparam longint ANGLE_PI   = 64'sd3373259426;
    localparam longint ANGLE_HALF = 64'sd1686629713;
    localparam longint GAIN_INIT  = 64'sd652032874;
    localparam longint UNIT_Q14   = 64'sd16384;

    localparam longint ATAN_STEP [24] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
        64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
        64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
        64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF,
        64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
        64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F
    };

    // first member lands in the top bits, so q_w sits at [15:0] as on the bus
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_t;

    quat_t quat_due [$];

    // sine and cosine of half the angle, 16 fraction bits
    function automatic void half_angle_trig(input logic signed [15:0] angle,
                                           output longint sin_h, output longint cos_h);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(angle) * 131072;
        x = GAIN_INIT;
        y = 0;
        flip = 1'b0;
        // fold into [-pi/2, pi/2], sign of both outputs flips
        if (z > ANGLE_HALF) begin
            z = z - ANGLE_PI;
            flip = 1'b1;
        end else if (z < -ANGLE_HALF) begin
            z = z + ANGLE_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_h = (x + 8192) >>> 14;
        sin_h = (y + 8192) >>> 14;
    endfunction

    // 48 fraction bits down to 14, round half up, clamp to plus or minus one
    function automatic logic [15:0] to_q14(input longint sum);
        longint q;
        q = (sum + (64'sd1 <<< 33)) >>> 34;
        if (q > UNIT_Q14) begin
            q = UNIT_Q14;
        end else if (q < -UNIT_Q14) begin
            q = -UNIT_Q14;
        end
        return q[15:0];
    endfunction

    function automatic quat_t euler_to_quat(input logic [47:0] angles);
        longint sr;
        longint cr;
        longint sp;
        longint cp;
        longint sy;
        longint cy;
        quat_t  q;
        half_angle_trig(angles[15:0], sr, cr);
        half_angle_trig(angles[31:16], sp, cp);
        half_angle_trig(angles[47:32], sy, cy);
        q.w = to_q14(cr * cp * cy + sr * sp * sy);
        q.x = to_q14(sr * cp * cy - cr * sp * sy);
        q.y = to_q14(cr * sp * cy + sr * cp * sy);
        q.z = to_q14(cr * cp * sy - sr * sp * cy);
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < 40) begin
            $display("mismatch %s: got %0d expected %0d at %0t",
                     what, $signed(got), $signed(want), $time);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        quat_t want;
        quat_t got;
        if (!aresetn) begin
            quat_due.delete();
            quats_due <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (quat_due.size() == 0) begin
                    report_mismatch("result with nothing due, q_w", got.w, 16'd0);
                end else begin
                    want = quat_due.pop_front();
                    if (got.w !== want.w) report_mismatch("q_w", got.w, want.w);
                    if (got.x !== want.x) report_mismatch("q_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("q_y", got.y, want.y);
                    if (got.z !== want.z) report_mismatch("q_z", got.z, want.z);
                end
            end
            if (s_tvalid && s_tready) begin
                quat_due.push_back(euler_to_quat(s_tdata));
            end
            quats_due <= quat_due.size();
        end
    end

endmodule

// File: test/tb_euler_to_quaternion.sv
module tb_euler_to_quaternion;

    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 4000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;   // roll_angle, pitch_angle, yaw_angle
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;         // q_w, q_x, q_y, q_z

    int mismatch_count;
    int quats_due;
    int idle_cycles = 0;
    int rx_cycle    = 0;
    int rx_mode     = 0;

    euler_to_quaternion uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    e2q_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .quats_due      (quats_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver backpressure, pattern picked at random from four modes
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                m_tready = 1'b1;
            end
            1: begin
                m_tready = 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready = (rx_cycle % 5 == 0);
            end
            default: begin
                m_tready = ($urandom_range(0, 9) != 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_euler_to_quaternion failed");
                $finish;
            end
        end
    end

    int burst_left = 0;

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  = {yaw, pitch, roll};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return 16'($urandom_range(0, 65535));
        end else if (sel < 8) begin
            return 16'($signed($urandom_range(0, 26000)) - 13000);
        end else if (sel < 9) begin
            // close to where the half angle crosses pi/2
            return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(12860, 12880))
                                              : 16'(-$urandom_range(12860, 12880));
        end else begin
            return 16'($signed($urandom_range(0, 64)) - 32);
        end
    endfunction

    logic [47:0] directed_angles [16] = '{
        {16'sd0,      16'sd0,      16'sd0},
        {16'sd32767,  16'sd32767,  16'sd32767},
        {-16'sd32768, -16'sd32768, -16'sd32768},
        {16'sd0,      -16'sd32768, 16'sd32767},
        {16'sd32767,  16'sd0,      -16'sd32768},
        {16'sd12868,  16'sd12868,  16'sd12868},
        {16'sd12869,  16'sd12869,  16'sd12869},
        {-16'sd12870, -16'sd12869, -16'sd12868},
        {16'sd0,      -16'sd12869, 16'sd12869},
        {16'sd6434,   16'sd6434,   16'sd6434},
        {-16'sd6434,  16'sd6434,   -16'sd6434},
        {16'sd25736,  -16'sd25736, 16'sd25736},
        {16'sd1,      -16'sd1,     16'sd1},
        {-16'sd16384, 16'sd0,      16'sd16384},
        {16'sd0,      16'sd6434,   16'sd0},
        {16'h5555,    16'hAAAA,    16'h7FFE}
    };

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_angles[i]) begin
            send_angles(directed_angles[i][15:0], directed_angles[i][31:16],
                        directed_angles[i][47:32]);
        end
        repeat (RANDOM_ITEMS) begin
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        s_tvalid = 1'b0;

        while (quats_due != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0 && quats_due == 0) begin
            $display("tb_euler_to_quaternion passed");
        end else begin
            $display("tb_euler_to_quaternion failed");
        end
        $finish;
    end

endmodule
